// File: rtl/ckrl_pkg.sv
// Package for the color keyed region labeler: shared constants, types, and the
// controller-to-cell command struct. No dependencies.
`timescale 1ns / 1ps
package ckrl_pkg;

	localparam int MAX_REGIONS_DEF = 64;
	localparam int COORD_BITS_DEF  = 11;
	localparam int FRAC_BITS_DEF   = 4;

	localparam int COLOR_W  = 24;
	localparam int COUNT_W  = 23;
	localparam int SUM_W    = 34;
	localparam int CENT_W   = 16;
	localparam int OFF_W    = 11;
	localparam int LABEL_W  = 6;
	localparam int INUSE_W  = 7;
	localparam int FIELD_W  = 11;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;

	localparam logic [0:0] CFG_OFFSET_X = 1'b0;
	localparam logic [0:0] CFG_OFFSET_Y = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_OUT
	} ctl_state_t;

	// Command broadcast from the controller into the cell row.
	typedef struct packed {
		logic                 compare;  // match color against every cell
		logic                 update;   // accumulate into the hit cell
		logic                 alloc;    // write color into the allocated cell
		logic [COLOR_W-1:0]   color;
		logic [FIELD_W-1:0]   px;
		logic [FIELD_W-1:0]   py;
	} cell_cmd_t;

endpackage

// File: rtl/ckrl_cell.sv
// One region cell: holds a color key, pixel count and coordinate sums, and
// passes the hit-chain and readout shift data to its neighbor. Uses ckrl_pkg.
`timescale 1ns / 1ps
module ckrl_cell #(
	parameter int IDX_W = 6
) (
	input  logic                         clk,
	input  ckrl_pkg::cell_cmd_t          cmd,
	input  logic                         alloc_sel,
	input  logic                         valid_in,
	input  logic                         hit_in,
	input  logic [IDX_W-1:0]             hit_idx_in,
	input  logic [IDX_W-1:0]             my_idx,
	output logic                         hit_out,
	output logic [IDX_W-1:0]             hit_idx_out,
	input  logic                         shift,
	input  logic [ckrl_pkg::COUNT_W+2*ckrl_pkg::SUM_W-1:0] rd_in,
	output logic [ckrl_pkg::COUNT_W+2*ckrl_pkg::SUM_W-1:0] rd_out
);
	import ckrl_pkg::*;

	logic [COLOR_W-1:0] color_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sumx_q;
	logic [SUM_W-1:0]   sumy_q;
	logic               match;
	logic               do_acc;

	// First matching cell wins: chain the hit from lower indexes upward
	assign match       = valid_in && (color_q == cmd.color);
	assign hit_out     = hit_in || match;
	assign hit_idx_out = hit_in ? hit_idx_in : my_idx;
	assign do_acc      = cmd.update && match && !hit_in && (count_q != COUNT_MAX);
	assign rd_out      = {count_q, sumx_q, sumy_q};

	// Allocate, accumulate or rotate the readout ring
	always_ff @(posedge clk) begin
		if (cmd.alloc && alloc_sel) begin
			color_q <= cmd.color;
			count_q <= COUNT_W'(1);
			sumx_q  <= SUM_W'(cmd.px);
			sumy_q  <= SUM_W'(cmd.py);
		end else if (do_acc) begin
			count_q <= count_q + COUNT_W'(1);
			sumx_q  <= sumx_q + SUM_W'(cmd.px);
			sumy_q  <= sumy_q + SUM_W'(cmd.py);
		end else if (shift) begin
			{count_q, sumx_q, sumy_q} <= rd_in;
		end
	end
endmodule

// File: rtl/ckrl_div.sv
// Restoring divider for centroids: one quotient bit per cycle, plus offset
// and saturation. Uses ckrl_pkg.
`timescale 1ns / 1ps
module ckrl_div #(
	parameter int FRAC_BITS = ckrl_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ckrl_pkg::SUM_W-1:0]    sum,
	input  logic [ckrl_pkg::COUNT_W-1:0]  count,
	input  logic [ckrl_pkg::OFF_W-1:0]    offset,
	output logic                          done,
	output logic [ckrl_pkg::CENT_W-1:0]   result
);
	import ckrl_pkg::*;

	localparam int NUM_W = SUM_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int ADD_W = NUM_W + 1;

	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   quo_q;
	logic [COUNT_W:0]   rem_q;
	logic [COUNT_W-1:0] den_q;
	logic [OFF_W-1:0]   off_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   rem_sh;
	logic [ADD_W-1:0]   total;

	assign rem_sh = {rem_q[COUNT_W-1:0], num_q[NUM_W-1]};
	assign trial  = rem_sh - {1'b0, den_q};

	// Hold busy while quotient bits remain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	// Shift one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_W'(sum) << FRAC_BITS;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= count;
			off_q <= offset;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!trial[COUNT_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done  = busy_q && (cnt_q == CNT_W'(1)) ? 1'b0 : !busy_q;
	assign total = ADD_W'(quo_q) + (ADD_W'(off_q) << FRAC_BITS);
	assign result = (total > ADD_W'({CENT_W{1'b1}})) ? {CENT_W{1'b1}} : total[CENT_W-1:0];
endmodule

// File: rtl/color_keyed_region_labeler_core.sv
// Color keyed region labeler top level: controller, row of region cells and
// centroid divider. Uses ckrl_pkg, ckrl_cell, ckrl_div.
//
// Usage: items enter on s_axis (tdata fields below), one result leaves on
// m_axis per item. Offsets must be written on the cfg port only while idle;
// the block itself does not enforce this. A pixel item is compared against
// the whole cell row in the cycle after it is accepted (match chain plus
// update of the hit or allocated cell); its result is registered with that
// update, and the next item is taken only after the result is.
// A readout of an allocated region rotates the cell ring until the queried
// region sits in cell zero, then runs two serial divisions, x then y, one
// quotient bit per cycle. While the result waits the ring rotates on to its
// home position, and the next item is taken only once the result has been
// taken and the ring is home.
// One item is in work at a time; s_axis_tready is low while it is.
// A stalled receiver holds the result in the output register and the next
// item waits. Reset clears the region count, offsets and handshake state;
// cell contents stay undefined until allocated.
`timescale 1ns / 1ps
module color_keyed_region_labeler_core #(
	parameter int MAX_REGIONS = ckrl_pkg::MAX_REGIONS_DEF,
	parameter int COORD_BITS  = ckrl_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS   = ckrl_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[0], pixel_x[11:1], pixel_y[22:12], red[30:23], green[38:31],
	// blue[46:39], region_query[52:47], zero fill
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// labeled[0], label[6:1], is_new_region[7], table_full[8],
	// regions_in_use[15:9], region_pixels[38:16], centroid_x[54:39],
	// centroid_y[70:55], zero fill
	output logic [71:0] m_axis_tdata
);
	import ckrl_pkg::*;

	localparam int IDX_W = $clog2(MAX_REGIONS);
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int RD_W  = COUNT_W + 2 * SUM_W;

	ctl_state_t state_q, state_d;
	logic [OFF_W-1:0]   offx_q, offy_q;
	logic [CNT_W-1:0]   alloc_q;
	logic               mode_q;
	logic [FIELD_W-1:0] px_q, py_q;
	logic [COLOR_W-1:0] color_q;
	logic [LABEL_W-1:0] query_q;
	logic [IDX_W-1:0]   rot_q;
	logic               divy_q;
	logic [CENT_W-1:0]  cx_q;
	logic [71:0]        out_q;
	logic               out_valid_q;

	cell_cmd_t          cmd;
	logic               hit_c [MAX_REGIONS+1];
	logic [IDX_W-1:0]   hidx_c [MAX_REGIONS+1];
	logic [RD_W-1:0]    rd_c [MAX_REGIONS];
	logic               shift;
	logic               keyed, hit, full, q_ok;
	logic               div_start, div_done;
	logic [CENT_W-1:0]  div_res;
	logic [SUM_W-1:0]   div_sum;
	logic [COUNT_W-1:0] head_cnt;
	logic [SUM_W-1:0]   head_sx, head_sy;
	logic [71:0]        pix_res;
	logic [LABEL_W-1:0] lbl;
	logic               accept;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign {head_cnt, head_sx, head_sy} = rd_c[0];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offx_q <= '0;
			offy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_X: offx_q <= cfg_data;
				CFG_OFFSET_Y: offy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= s_axis_tdata[0];
			px_q    <= s_axis_tdata[11:1] & FIELD_W'((1 << COORD_BITS) - 1);
			py_q    <= s_axis_tdata[22:12] & FIELD_W'((1 << COORD_BITS) - 1);
			color_q <= s_axis_tdata[46:23] ^ 24'h0 ;
			query_q <= s_axis_tdata[52:47];
		end
	end

	// Build the broadcast command to the cells
	assign keyed = (color_q != COLOR_WHITE) && (color_q != COLOR_BLACK);
	always_comb begin
		cmd         = '0;
		cmd.color   = {color_q[7:0], color_q[15:8], color_q[23:16]};
		cmd.px      = px_q;
		cmd.py      = py_q;
		cmd.compare = (state_q == ST_SCAN) && !mode_q;
		cmd.update  = cmd.compare && keyed;
		cmd.alloc   = cmd.update && !hit && (32'(alloc_q) < MAX_REGIONS);
	end

	assign hit_c[0]  = 1'b0;
	assign hidx_c[0] = '0;
	// Rotate toward the queried region, then on to home while the result waits
	assign shift = ((state_q == ST_SCAN) && mode_q && q_ok && (rot_q != IDX_W'(query_q)))
		|| ((state_q == ST_OUT) && (rot_q != '0));

	// Row of region cells; the readout data rotates as a ring
	for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
		ckrl_cell #(.IDX_W(IDX_W)) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.alloc_sel  (32'(alloc_q) == g),
			.valid_in   (32'(alloc_q) > g),
			.hit_in     (hit_c[g]),
			.hit_idx_in (hidx_c[g]),
			.my_idx     (IDX_W'(g)),
			.hit_out    (hit_c[g+1]),
			.hit_idx_out(hidx_c[g+1]),
			.shift      (shift),
			.rd_in      (rd_c[(g + 1) % MAX_REGIONS]),
			.rd_out     (rd_c[g])
		);
	end

	assign hit  = hit_c[MAX_REGIONS];
	assign full = !hit && (32'(alloc_q) >= MAX_REGIONS);
	assign q_ok = (CNT_W'(query_q) < alloc_q) && (32'(query_q) < MAX_REGIONS);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_SCAN;
			ST_SCAN: begin
				if (!mode_q || !q_ok) state_d = ST_OUT;
				else if (!shift) state_d = ST_DIV;
			end
			ST_DIV:  if (div_done && divy_q && !div_start) state_d = ST_OUT;
			ST_OUT:  if (!out_valid_q && (rot_q == '0)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Divider control outputs
	always_comb begin
		div_start = 1'b0;
		div_sum   = divy_q ? head_sy : head_sx;
		if (state_q == ST_SCAN && mode_q && q_ok && !shift) div_start = 1'b1;
		if (state_q == ST_DIV && div_done && !divy_q) div_start = 1'b1;
		if (state_q == ST_DIV && div_done && !divy_q) div_sum = head_sy;
	end

	ckrl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (div_sum),
		.count  (head_cnt),
		.offset (divy_q || (state_q == ST_DIV && div_done) ? offy_q : offx_q),
		.done   (div_done),
		.result (div_res)
	);

	assign lbl = LABEL_W'(hidx_c[MAX_REGIONS]);
	always_comb begin
		pix_res = '0;
		if (keyed && !full) begin
			pix_res[0]   = 1'b1;
			pix_res[6:1] = hit ? lbl : LABEL_W'(alloc_q);
			pix_res[7]   = !hit;
		end
		pix_res[8]    = keyed && full;
		pix_res[15:9] = INUSE_W'(alloc_q) + INUSE_W'(keyed && !hit && !full);
	end

	// Control registers, rotation position and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			alloc_q     <= '0;
			rot_q       <= '0;
			divy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (shift) rot_q <= (32'(rot_q) == MAX_REGIONS - 1) ? '0 : rot_q + IDX_W'(1);
			if (state_q == ST_SCAN) begin
				if (!mode_q) begin
					if (cmd.alloc) alloc_q <= alloc_q + CNT_W'(1);
					out_valid_q <= 1'b1;
				end else if (!q_ok) begin
					out_valid_q <= 1'b1;
				end
			end
			if (state_q == ST_DIV && div_done && !div_start) begin
				if (!divy_q) divy_q <= 1'b1;
			end
			if (state_q == ST_DIV && div_done && divy_q && !div_start) begin
				divy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end
			if (state_q == ST_DIV && div_start) divy_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_start) cx_q <= div_res;
		if (state_q == ST_SCAN) begin
			if (!mode_q) out_q <= pix_res;
			else out_q <= {1'b0, 16'd0, 16'd0, 23'd0, INUSE_W'(alloc_q), 2'b00,
				query_q, 1'b0};
		end
		if (state_q == ST_DIV && div_done && divy_q && !div_start) begin
			out_q <= {1'b0, div_res, cx_q, head_cnt, out_q[15:1], 1'b1};
		end
	end

	assign m_axis_tvalid = out_valid_q && (state_q == ST_OUT);
	assign m_axis_tdata  = out_q;
endmodule

// File: tb/sv/tb_color_keyed_region_labeler_core.sv
// Testbench for color_keyed_region_labeler_core: directed table, then random pixel
// and readout items checked against a behavioral predictor. Depends on ckrl_pkg.
`timescale 1ns / 1ps
module tb_color_keyed_region_labeler_core;
	import ckrl_pkg::*;

	localparam int NREG = 64;
	localparam logic [15:0] CENT_SAT = 16'hFFFF;
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_READ  = 1'b1;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [5:0]  query;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [10:0] py;
		logic [10:0] px;
		logic        mode;
	} pix_item_t;

	typedef struct packed {
		logic [15:0] cy;
		logic [15:0] cx;
		logic [22:0] npix;
		logic [6:0]  in_use;
		logic        full;
		logic        is_new;
		logic [5:0]  label;
		logic        labeled;
	} label_res_t;

	typedef struct {
		pix_item_t  item;
		logic       has_exp;
		label_res_t exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_OFFSET_X;
	logic [10:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;

	// predictor state
	logic [23:0] col_tab [NREG];
	logic [22:0] cnt_tab [NREG];
	logic [33:0] sx_tab [NREG];
	logic [33:0] sy_tab [NREG];
	int unsigned n_alloc;
	logic [10:0] off_x, off_y;

	label_res_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 0;
	bit sending_done = 0;
	bit long_stall_req = 0;

	always #4 clk = ~clk;

	color_keyed_region_labeler_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic logic [15:0] centroid_q12_4(logic [33:0] sum, logic [22:0] n,
			logic [10:0] off);
		logic [63:0] v;
		v = ({30'd0, sum} << 4) / {41'd0, n};
		v = v + ({53'd0, off} << 4);
		return (v > 64'hFFFF) ? CENT_SAT : v[15:0];
	endfunction

	// Compute the result of one item and advance the region state.
	function automatic label_res_t predict_label(pix_item_t it);
		label_res_t r;
		logic [23:0] c;
		int hit;
		r = '0;
		c = {it.red, it.green, it.blue};
		if (it.mode == MODE_PIXEL) begin
			if (c != COLOR_WHITE && c != COLOR_BLACK) begin
				hit = -1;
				for (int i = 0; i < n_alloc; i++)
					if (hit < 0 && col_tab[i] == c) hit = i;
				if (hit >= 0) begin
					r.labeled = 1;
					r.label = hit[5:0];
					if (cnt_tab[hit] < COUNT_MAX) begin
						cnt_tab[hit]++;
						sx_tab[hit] += it.px;
						sy_tab[hit] += it.py;
					end
				end else if (n_alloc < NREG) begin
					col_tab[n_alloc] = c;
					cnt_tab[n_alloc] = 1;
					sx_tab[n_alloc] = it.px;
					sy_tab[n_alloc] = it.py;
					r.labeled = 1;
					r.label = n_alloc[5:0];
					r.is_new = 1;
					n_alloc++;
				end else begin
					r.full = 1;
				end
			end
		end else begin
			r.label = it.query;
			if (it.query < n_alloc) begin
				r.labeled = 1;
				r.npix = cnt_tab[it.query];
				r.cx = centroid_q12_4(sx_tab[it.query], cnt_tab[it.query], off_x);
				r.cy = centroid_q12_4(sy_tab[it.query], cnt_tab[it.query], off_y);
			end
		end
		r.in_use = n_alloc[6:0];
		return r;
	endfunction

	task automatic write_offset(logic [0:0] idx, logic [10:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_OFFSET_X) off_x = val; else off_y = val;
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Offer one item, with an optional random gap, and hold until accepted.
	task automatic send_item(pix_item_t it, bit gap, bit has_exp = 0,
			label_res_t fixed = '0);
		label_res_t p;
		int g;
		if (gap) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			if (g != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b0, it};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		p = predict_label(it);
		if (has_exp && p != fixed) begin
			errors++;
			if (errors <= 10)
				$display("table row disagrees with predictor: %h vs %h", fixed, p);
		end
		expected_q.insert(expected_q.size(), p);
	endtask

	function automatic pix_item_t make_pixel(logic [23:0] c, logic [10:0] x, logic [10:0] y);
		pix_item_t it;
		it = '0;
		it.mode = MODE_PIXEL;
		it.red = c[23:16]; it.green = c[15:8]; it.blue = c[7:0];
		it.px = x; it.py = y;
		it.query = 6'($urandom);
		return it;
	endfunction

	function automatic pix_item_t make_read(logic [5:0] q);
		pix_item_t it;
		it = 53'({$urandom, $urandom});
		it.px = 11'($urandom); it.py = 11'($urandom);
		it.mode = MODE_READ;
		it.query = q;
		return it;
	endfunction

	function automatic label_res_t res(logic lab, logic [5:0] l, logic nw, logic fl,
			logic [6:0] u, logic [22:0] n, logic [15:0] x, logic [15:0] y);
		label_res_t r;
		r = {y, x, n, u, fl, nw, l, lab};
		return r;
	endfunction

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_off) m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 3) == 0) m_axis_tready <= 1'b0;
		else m_axis_tready <= 1'b1;
	end

	// Long hold-off counted in its own process.
	initial begin
		wait (long_stall_req);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		label_res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[70:0];
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got != want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp lab=%0d lbl=%0d new=%0d full=%0d use=%0d n=%0d cx=%h cy=%h | got lab=%0d lbl=%0d new=%0d full=%0d use=%0d n=%0d cx=%h cy=%h",
							want.labeled, want.label, want.is_new, want.full, want.in_use,
							want.npix, want.cx, want.cy, got.labeled, got.label,
							got.is_new, got.full, got.in_use, got.npix, got.cx, got.cy);
				end
			end
		end
	end

	// Watchdog on cycles with no accepted item on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n
				|| hold_off || sending_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		dir_row_t rows [16];
		pix_item_t it;
		logic [23:0] pal [8];
		int k;
		n_alloc = 0;
		off_x = '0;
		off_y = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: readout after reset, black and white, extremes, hits.
		rows[0]  = '{make_read(6'd0), 1, res(0, 0, 0, 0, 0, 0, 0, 0)};
		rows[1]  = '{make_read(6'd63), 1, res(0, 63, 0, 0, 0, 0, 0, 0)};
		rows[2]  = '{make_pixel(24'h000000, 11'd5, 11'd5), 1, res(0, 0, 0, 0, 0, 0, 0, 0)};
		rows[3]  = '{make_pixel(24'hFFFFFF, 11'd7, 11'd7), 1, res(0, 0, 0, 0, 0, 0, 0, 0)};
		rows[4]  = '{make_pixel(24'h000001, 11'd2047, 11'd0), 1, res(1, 0, 1, 0, 1, 0, 0, 0)};
		rows[5]  = '{make_pixel(24'hFFFFFE, 11'd0, 11'd2047), 1, res(1, 1, 1, 0, 2, 0, 0, 0)};
		rows[6]  = '{make_read(6'd0), 1, res(1, 0, 0, 0, 2, 1, 16'h7FF0, 16'h0)};
		rows[7]  = '{make_read(6'd1), 1, res(1, 1, 0, 0, 2, 1, 16'h0, 16'h7FF0)};
		rows[8]  = '{make_pixel(24'h000001, 11'd0, 11'd2047), 0, '0};
		rows[9]  = '{make_pixel(24'h800000, 11'd3, 11'd4), 0, '0};
		rows[10] = '{make_pixel(24'h008000, 11'h555, 11'h2AA), 0, '0};
		rows[11] = '{make_pixel(24'h000080, 11'h2AA, 11'h555), 0, '0};
		rows[12] = '{make_read(6'd0), 0, '0};
		rows[13] = '{make_read(6'd2), 0, '0};
		rows[14] = '{make_read(6'd5), 0, '0};
		rows[15] = '{make_read(6'd40), 0, '0};
		foreach (rows[i]) send_item(rows[i].item, 0, rows[i].has_exp, rows[i].exp);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// Offset extremes on existing regions.
		write_offset(CFG_OFFSET_X, 11'h7FF);
		write_offset(CFG_OFFSET_Y, 11'h400);
		for (int q = 0; q < 6; q++) send_item(make_read(q[5:0]), 0);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		write_offset(CFG_OFFSET_X, 11'h155);
		write_offset(CFG_OFFSET_Y, 11'h2AA);

		// Random phase A: small palette, many hits; receiver holds off mid-way.
		for (int i = 0; i < 8; i++) pal[i] = {8'($urandom_range(1, 255)), 16'($urandom)};
		for (int n = 0; n < 250; n++) begin
			if (n == 60) long_stall_req = 1;
			k = $urandom_range(0, 19);
			if (k < 3) it = make_read(6'($urandom_range(0, 63)));
			else if (k == 3) it = make_pixel(($urandom_range(0, 1)) ? 24'hFFFFFF : 24'h0,
				11'($urandom), 11'($urandom));
			else it = make_pixel(pal[$urandom_range(0, 7)], 11'($urandom), 11'($urandom));
			send_item(it, n > 100);
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();
		write_offset(CFG_OFFSET_X, 11'd0);
		write_offset(CFG_OFFSET_Y, 11'd0);

		// Random phase B: fresh colors to fill the table and reach full.
		for (int n = 0; n < 420; n++) begin
			k = $urandom_range(0, 9);
			if (k < 2) it = make_read(6'($urandom_range(0, 63)));
			else if (k < 4 && n_alloc > 0) it = make_pixel(col_tab[$urandom_range(0, n_alloc - 1)],
				11'($urandom), 11'($urandom));
			else it = make_pixel(24'($urandom), 11'($urandom), 11'($urandom));
			send_item(it, 1);
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();
		write_offset(CFG_OFFSET_X, 11'h7FF);
		write_offset(CFG_OFFSET_Y, 11'h7FF);
		for (int q = 0; q < 10; q++) send_item(make_read(6'($urandom_range(0, 63))), 1);
		s_axis_tvalid <= 1'b0;

		sending_done = 1;
		fork
			begin
				wait_drained();
				if (errors == 0)
					$display("DONE: 0 errors");
				else
					$display("DONE: errors detected");
			end
			begin
				repeat (50000) @(posedge clk);
				$display("DONE: errors detected");
			end
		join_any
		$finish;
	end

endmodule
